>>> rtl/core/ffa_pkg.sv
package ffa_pkg;

    // Field widths fixed by the interface
    localparam int OFF_W = 16;
    localparam int SIZE_W = 17;
    // Free-list entries hold wide starts and saturating lengths
    localparam int ENT_W = 32;
    localparam logic [ENT_W-1:0] LEN_LIMIT = 32'h7FFF_FFFF;

    localparam int DEF_CAPACITY = 65536;
    localparam int DEF_MAX_FREE_BLOCKS = 64;
    localparam int DEF_MAX_COOLING = 64;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [OFF_W-1:0]  block_offset;
        logic [SIZE_W-1:0] block_size;
    } ffa_in_t;

    typedef struct packed {
        logic [OFF_W-1:0] result_offset;
        logic [1:0]       status;
    } ffa_out_t;

    typedef struct packed {
        logic [ENT_W-1:0] start;
        logic [ENT_W-1:0] len;
    } ffa_ent_t;

    typedef struct packed {
        logic [OFF_W-1:0]  start;
        logic [SIZE_W-1:0] len;
    } ffa_cool_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_A_CHK,
        S_SD_MV,
        S_T_RD,
        S_T_LD,
        S_I_SCAN,
        S_I_CMP,
        S_I_DEC,
        S_SU_MV,
        S_INS_WR,
        S_T_NEXT,
        S_T_END,
        S_DONE
    } ffa_step_t;

    typedef struct packed {
        ffa_step_t step;
        logic      accept;
    } ffa_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       free_empty;
        logic       free_full;
        logic       old_empty;
        logic       fit;
        logic       exact;
        logic       scan_last;
        logic       less;
        logic       mnext;
        logic       mprev;
        logic       pos_end;
        logic       pos_more;
        logic       sd_more;
        logic       su_done;
        logic       tick_last;
        logic       out_busy;
    } ffa_stat_t;

    function automatic logic [ENT_W-1:0] sat_add(input logic [ENT_W-1:0] a,
                                                  input logic [ENT_W-1:0] b);
        logic [ENT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, LEN_LIMIT}) ? LEN_LIMIT : s[ENT_W-1:0];
    endfunction

endpackage

>>> rtl/core/first_fit_deferred_free_allocator.sv
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    ffa_in_t  {cmd, block_offset, block_size}
// out      out  out_valid/out_ready  ffa_out_t {result_offset, status}
//
// One item is worked at a time by a sequencer over a free-list memory with one
// read and one write port. Free and no-op finish after dispatch. Allocate scans
// entries for the first fit and shifts later entries down on an exact fit.
// Tick inserts each old cooling block into the sorted free list, merging with
// neighbours and shifting entries up or down as needed.
// Reset is immediate; no clearing pass. The result sits in an output register,
// so a new item is taken while the previous result waits for out_ready.
module first_fit_deferred_free_allocator
    import ffa_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int MAX_FREE_BLOCKS = DEF_MAX_FREE_BLOCKS,
    parameter int MAX_COOLING = DEF_MAX_COOLING
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ffa_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output ffa_out_t out_data
);

    ffa_cmd_t  cmd;
    ffa_stat_t stat;

    // Sequencer: dispatch, first-fit scan, sorted insert with coalescing
    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Free list, cooling banks, counters and result register
    ffa_dp #(
        .CAPACITY        (CAPACITY),
        .MAX_FREE_BLOCKS (MAX_FREE_BLOCKS),
        .MAX_COOLING     (MAX_COOLING)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> rtl/core/ffa_ctrl.sv
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ffa_stat_t stat,
    output ffa_cmd_t  cmd
);

    ffa_step_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready = (state_reg == S_IDLE);
        cmd.step = state_reg;
        cmd.accept = (state_reg == S_IDLE) && in_valid;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.op)
                    CMD_ALLOC: state_next = stat.free_empty ? S_DONE : S_A_CHK;
                    CMD_TICK:  state_next = stat.old_empty ? S_T_END : S_T_RD;
                    default:   state_next = S_DONE;
                endcase
            end
            S_A_CHK:
            begin
                if (stat.fit)
                begin
                    state_next = (stat.exact && !stat.scan_last) ? S_SD_MV : S_DONE;
                end
                else if (stat.scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_SD_MV:
            begin
                if (!stat.sd_more)
                begin
                    state_next = (stat.op == CMD_ALLOC) ? S_DONE : S_T_NEXT;
                end
            end
            S_T_RD:
            begin
                state_next = S_T_LD;
            end
            S_T_LD:
            begin
                priority if (stat.free_full)
                begin
                    state_next = S_T_NEXT;
                end
                else if (stat.free_empty)
                begin
                    state_next = S_I_CMP;
                end
                else
                begin
                    state_next = S_I_SCAN;
                end
            end
            S_I_SCAN:
            begin
                if (!(stat.less && !stat.scan_last))
                begin
                    state_next = S_I_CMP;
                end
            end
            S_I_CMP:
            begin
                state_next = S_I_DEC;
            end
            S_I_DEC:
            begin
                priority if (!stat.mnext && !stat.mprev)
                begin
                    state_next = stat.pos_end ? S_INS_WR : S_SU_MV;
                end
                else if (stat.mnext && stat.mprev && stat.pos_more)
                begin
                    state_next = S_SD_MV;
                end
                else
                begin
                    state_next = S_T_NEXT;
                end
            end
            S_SU_MV:
            begin
                if (stat.su_done)
                begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                state_next = S_T_NEXT;
            end
            S_T_NEXT:
            begin
                state_next = stat.tick_last ? S_T_END : S_T_RD;
            end
            S_T_END:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/ffa_dp.sv
module ffa_dp
    import ffa_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int MAX_FREE_BLOCKS = DEF_MAX_FREE_BLOCKS,
    parameter int MAX_COOLING = DEF_MAX_COOLING
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ffa_cmd_t  cmd,
    output ffa_stat_t stat,
    input  ffa_in_t   in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output ffa_out_t  out_data
);

    localparam int FA_W = $clog2(MAX_FREE_BLOCKS);
    localparam int CNT_W = $clog2(MAX_FREE_BLOCKS + 1);
    localparam int XW = CNT_W + 1;
    localparam int CA_W = $clog2(MAX_COOLING);
    localparam int CC_W = $clog2(MAX_COOLING + 1);
    localparam int CX_W = CC_W + 1;
    localparam logic [ENT_W-1:0] CAP_LEN = ENT_W'(CAPACITY);
    localparam logic [XW-1:0] FREE_MAX = XW'(MAX_FREE_BLOCKS);
    localparam logic [CX_W-1:0] COOL_MAX = CX_W'(MAX_COOLING);

    // Free list memory, one read and one write port
    ffa_ent_t fmem [MAX_FREE_BLOCKS];
    ffa_ent_t frd_reg;
    logic fwe;
    logic [FA_W-1:0] fwaddr, fraddr;
    ffa_ent_t fwdata, frd;

    // Cooling lists: two banks, old bank selected by bank_reg
    ffa_cool_t cmem [2**(CA_W+1)];
    ffa_cool_t crd_reg;
    logic cwe;
    logic [CA_W:0] cwaddr, craddr;
    ffa_cool_t cwdata;

    logic [1:0]         op_reg, op_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [SIZE_W-1:0]  sz_reg, sz_next;
    logic [1:0]         status_reg, status_next;
    logic [OFF_W-1:0]   result_reg, result_next;
    logic [FA_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    ffa_ent_t           prev_reg, prev_next, nxt_reg, nxt_next;
    logic               prev_v_reg, prev_v_next, nxt_v_reg, nxt_v_next;
    logic               mnext_reg, mnext_next, mprev_reg, mprev_next;
    logic [OFF_W-1:0]   s_reg, s_next;
    logic [ENT_W-1:0]   len_reg, len_next;
    logic [CA_W-1:0]    tidx_reg, tidx_next;
    logic [CNT_W-1:0]   fcnt_reg, fcnt_next;
    logic [CC_W-1:0]    ycnt_reg, ycnt_next, ocnt_reg, ocnt_next;
    logic               bank_reg, bank_next;
    logic               init_reg, init_next, init_hit_reg, init_hit_next;
    logic               out_valid_reg, out_valid_next;
    ffa_out_t           out_data_reg, out_data_next;

    logic [XW-1:0] idx_x, pos_x, cnt_x;

    assign idx_x = XW'(idx_reg);
    assign pos_x = XW'(pos_reg);
    assign cnt_x = XW'(fcnt_reg);
    assign frd = init_hit_reg ? '{start: '0, len: CAP_LEN} : frd_reg;
    assign craddr = {bank_reg, tidx_reg};

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    always_comb
    begin
        stat.op = op_reg;
        stat.free_empty = (fcnt_reg == '0);
        stat.free_full = (cnt_x >= FREE_MAX);
        stat.old_empty = (ocnt_reg == '0);
        stat.fit = (frd.len >= ENT_W'(sz_reg));
        stat.exact = (frd.len == ENT_W'(sz_reg));
        stat.scan_last = (idx_x + XW'(1) >= cnt_x);
        stat.less = (frd.start < ENT_W'(s_reg));
        stat.mnext = mnext_reg;
        stat.mprev = mprev_reg;
        stat.pos_end = (pos_x == cnt_x);
        stat.pos_more = (pos_x + XW'(1) < cnt_x);
        stat.sd_more = (idx_x + XW'(2) < cnt_x);
        stat.su_done = (idx_x == pos_x);
        stat.tick_last = (CC_W'(tidx_reg) + CC_W'(1) == ocnt_reg);
        stat.out_busy = out_valid_reg && !out_ready;
    end

    always_comb
    begin
        op_next = op_reg;
        off_next = off_reg;
        sz_next = sz_reg;
        status_next = status_reg;
        result_next = result_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        prev_next = prev_reg;
        nxt_next = nxt_reg;
        prev_v_next = prev_v_reg;
        nxt_v_next = nxt_v_reg;
        mnext_next = mnext_reg;
        mprev_next = mprev_reg;
        s_next = s_reg;
        len_next = len_reg;
        tidx_next = tidx_reg;
        fcnt_next = fcnt_reg;
        ycnt_next = ycnt_reg;
        ocnt_next = ocnt_reg;
        bank_next = bank_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next = out_data_reg;
        fwe = 1'b0;
        fwaddr = idx_reg;
        fwdata = frd;
        fraddr = idx_reg + FA_W'(1);
        cwe = 1'b0;
        cwaddr = {~bank_reg, ycnt_reg[CA_W-1:0]};
        cwdata = '{start: off_reg, len: sz_reg};

        unique case (cmd.step)
            S_IDLE:
            begin
                fraddr = '0;
                if (cmd.accept)
                begin
                    op_next = in_data.cmd;
                    off_next = in_data.block_offset;
                    sz_next = in_data.block_size;
                    status_next = ST_OK;
                    result_next = '0;
                    idx_next = '0;
                    tidx_next = '0;
                end
            end
            S_DISP:
            begin
                fraddr = '0;
                if (op_reg == CMD_ALLOC && fcnt_reg == '0)
                begin
                    status_next = ST_NOFIT;
                end
                else if (op_reg == CMD_FREE && sz_reg != '0)
                begin
                    if (CX_W'(ycnt_reg) < COOL_MAX)
                    begin
                        cwe = 1'b1;
                        ycnt_next = ycnt_reg + CC_W'(1);
                    end
                    else
                    begin
                        status_next = ST_DROP;
                    end
                end
            end
            S_A_CHK:
            begin
                if (stat.fit)
                begin
                    result_next = frd.start[OFF_W-1:0];
                    if (!stat.exact)
                    begin
                        fwe = 1'b1;
                        fwdata.start = frd.start + ENT_W'(sz_reg);
                        fwdata.len = frd.len - ENT_W'(sz_reg);
                    end
                    else if (stat.scan_last)
                    begin
                        fcnt_next = fcnt_reg - CNT_W'(1);
                    end
                end
                else if (stat.scan_last)
                begin
                    status_next = ST_NOFIT;
                end
                else
                begin
                    idx_next = idx_reg + FA_W'(1);
                end
            end
            S_SD_MV:
            begin
                // remove: pull entry idx+1 down into idx
                fwe = 1'b1;
                fraddr = FA_W'(idx_x + XW'(2));
                idx_next = idx_reg + FA_W'(1);
                if (!stat.sd_more)
                begin
                    fcnt_next = fcnt_reg - CNT_W'(1);
                end
            end
            S_T_RD:
            begin
            end
            S_T_LD:
            begin
                s_next = crd_reg.start;
                len_next = ENT_W'(crd_reg.len);
                idx_next = '0;
                pos_next = '0;
                prev_v_next = 1'b0;
                nxt_v_next = 1'b0;
                fraddr = '0;
                if (stat.free_full)
                begin
                    status_next = ST_DROP;
                end
            end
            S_I_SCAN:
            begin
                if (stat.less)
                begin
                    prev_next = frd;
                    prev_v_next = 1'b1;
                    if (stat.scan_last)
                    begin
                        pos_next = fcnt_reg;
                    end
                    else
                    begin
                        idx_next = idx_reg + FA_W'(1);
                    end
                end
                else
                begin
                    nxt_next = frd;
                    nxt_v_next = 1'b1;
                    pos_next = CNT_W'(idx_reg);
                end
            end
            S_I_CMP:
            begin
                mnext_next = nxt_v_reg &&
                    (({{(ENT_W-OFF_W+1){1'b0}}, s_reg} + {1'b0, len_reg}) ==
                     {1'b0, nxt_reg.start});
                mprev_next = prev_v_reg &&
                    (({1'b0, prev_reg.start} + {1'b0, prev_reg.len}) ==
                     {{(ENT_W-OFF_W+1){1'b0}}, s_reg});
                if (mnext_next)
                begin
                    len_next = sat_add(len_reg, nxt_reg.len);
                end
            end
            S_I_DEC:
            begin
                if (!mnext_reg && !mprev_reg)
                begin
                    if (!stat.pos_end)
                    begin
                        idx_next = FA_W'(cnt_x - XW'(1));
                        fraddr = FA_W'(cnt_x - XW'(1));
                    end
                end
                else if (mprev_reg)
                begin
                    fwe = 1'b1;
                    fwaddr = FA_W'(pos_x - XW'(1));
                    fwdata.start = prev_reg.start;
                    fwdata.len = sat_add(prev_reg.len, len_reg);
                    if (mnext_reg)
                    begin
                        idx_next = FA_W'(pos_reg);
                        fraddr = FA_W'(pos_x + XW'(1));
                        if (!stat.pos_more)
                        begin
                            fcnt_next = fcnt_reg - CNT_W'(1);
                        end
                    end
                end
                else
                begin
                    fwe = 1'b1;
                    fwaddr = FA_W'(pos_reg);
                    fwdata.start = ENT_W'(s_reg);
                    fwdata.len = len_reg;
                end
            end
            S_SU_MV:
            begin
                // make room: push entry idx up into idx+1
                fwe = 1'b1;
                fwaddr = idx_reg + FA_W'(1);
                fraddr = idx_reg - FA_W'(1);
                if (!stat.su_done)
                begin
                    idx_next = idx_reg - FA_W'(1);
                end
            end
            S_INS_WR:
            begin
                fwe = 1'b1;
                fwaddr = FA_W'(pos_reg);
                fwdata.start = ENT_W'(s_reg);
                fwdata.len = len_reg;
                fcnt_next = fcnt_reg + CNT_W'(1);
            end
            S_T_NEXT:
            begin
                tidx_next = tidx_reg + CA_W'(1);
            end
            S_T_END:
            begin
                bank_next = ~bank_reg;
                ocnt_next = ycnt_reg;
                ycnt_next = '0;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.result_offset = result_reg;
                    out_data_next.status = status_reg;
                end
            end
            default:
            begin
            end
        endcase

        init_next = init_reg && !(fwe && fwaddr == '0);
        init_hit_next = init_reg && (fraddr == '0);
    end

    always_ff @(posedge clk)
    begin
        if (fwe)
        begin
            fmem[fwaddr] <= fwdata;
        end
        frd_reg <= fmem[fraddr];
    end

    always_ff @(posedge clk)
    begin
        if (cwe)
        begin
            cmem[cwaddr] <= cwdata;
        end
        crd_reg <= cmem[craddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= CMD_NOP;
            status_reg <= ST_OK;
            idx_reg <= '0;
            pos_reg <= '0;
            prev_v_reg <= 1'b0;
            nxt_v_reg <= 1'b0;
            mnext_reg <= 1'b0;
            mprev_reg <= 1'b0;
            tidx_reg <= '0;
            fcnt_reg <= CNT_W'(1);
            ycnt_reg <= '0;
            ocnt_reg <= '0;
            bank_reg <= 1'b0;
            init_reg <= 1'b1;
            init_hit_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            op_reg <= op_next;
            status_reg <= status_next;
            idx_reg <= idx_next;
            pos_reg <= pos_next;
            prev_v_reg <= prev_v_next;
            nxt_v_reg <= nxt_v_next;
            mnext_reg <= mnext_next;
            mprev_reg <= mprev_next;
            tidx_reg <= tidx_next;
            fcnt_reg <= fcnt_next;
            ycnt_reg <= ycnt_next;
            ocnt_reg <= ocnt_next;
            bank_reg <= bank_next;
            init_reg <= init_next;
            init_hit_reg <= init_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
        sz_reg <= sz_next;
        result_reg <= result_next;
        prev_reg <= prev_next;
        nxt_reg <= nxt_next;
        s_reg <= s_next;
        len_reg <= len_next;
        out_data_reg <= out_data_next;
    end

endmodule
